>>> hdl/rbps_pkg.sv
// Package for the ready bitmap priority scheduler.
// Holds the sizing constants, command and status codes, and the transaction types.
// No dependencies.
package rbps_pkg;

    localparam int PRIO_COUNT = 32;
    localparam int PRIO_W = (PRIO_COUNT > 1) ? $clog2(PRIO_COUNT) : 1;
    localparam int CNT_W = 8;
    localparam int LOCK_W = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;
    localparam logic [LOCK_W-1:0] LOCK_MAX = 8'd255;

    localparam logic [2:0] CMD_READY = 3'd0;
    localparam logic [2:0] CMD_UNREADY = 3'd1;
    localparam logic [2:0] CMD_QUERY = 3'd2;
    localparam logic [2:0] CMD_LOCK = 3'd3;
    localparam logic [2:0] CMD_UNLOCK = 3'd4;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
    localparam logic [1:0] STATUS_NOT_LOCKED = 2'd3;

    typedef struct packed {
        logic [2:0] cmd;
        logic [5:0] priority_req;
    } req_t;

    typedef struct packed {
        logic [5:0] top_priority;
        logic       any_ready;
        logic       sched_allowed;
        logic       reschedule;
        logic [1:0] status;
    } rsp_t;

endpackage

>>> hdl/rbps_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// The read data holds its value in cycles without a read enable.
// No dependencies.
module rbps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/rbps_encode.sv
// Two-level priority encoder over the group byte and the per-priority bitmap.
// Depends on rbps_pkg.
module rbps_encode
    import rbps_pkg::*;
(
    input  logic [PRIO_COUNT-1:0] prio_bits,
    input  logic [7:0]            group_bits,
    output logic [5:0]            top_priority,
    output logic                  any_ready
);

    function automatic logic [2:0] low_bit8(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    logic [63:0] bits_wide;
    logic [2:0]  grp;
    logic [7:0]  grp_byte;

    always_comb
    begin
        bits_wide = 64'(prio_bits);
        any_ready = |group_bits;
        grp = low_bit8(group_bits);
        grp_byte = bits_wide[{grp, 3'b000} +: 8];
        top_priority = any_ready ? {grp, low_bit8(grp_byte)} : 6'd0;
    end

endmodule

>>> hdl/ready_bitmap_priority_scheduler.sv
// Top level of the ready bitmap priority scheduler.
// Depends on rbps_pkg, rbps_ram and rbps_encode.
//
// Usage:
// The req channel carries one command per transaction (mark a priority ready or
// not ready, query, lock or unlock). The rsp channel returns one transaction per
// command with the highest ready priority, the lock state, the reschedule flag
// and a status code, all taken after the command's update.
// Each command reads the ready count of its priority from the count RAM in the
// accept cycle and writes it back in the update state, when the response is
// loaded into the output register. A new command is accepted only after that
// read-modify-write of the count RAM has completed, so commands do not overlap.
// After reset all counts read as zero through per-entry valid bits, no priority
// is ready and the scheduler is unlocked; no clearing pass is needed.
// When the receiver stalls, the response waits in the output register; a new
// command is still accepted, and it waits in the update state until the output
// register is free.
module ready_bitmap_priority_scheduler
    import rbps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic [2:0]            cmd_reg;
    logic [5:0]            prio_reg;
    logic [PRIO_COUNT-1:0] valid_reg;
    logic [PRIO_COUNT-1:0] prio_bits_reg;
    logic [PRIO_COUNT-1:0] prio_bits_next;
    logic [7:0]            group_bits_reg;
    logic [7:0]            group_bits_next;
    logic [LOCK_W-1:0]     lock_reg;
    logic [LOCK_W-1:0]     lock_next;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;

    logic                  accept;
    logic                  complete;
    logic [PRIO_W-1:0]     addr;
    logic [CNT_W-1:0]      rd_data;
    logic [CNT_W-1:0]      cnt;
    logic [CNT_W-1:0]      cnt_next;
    logic                  cnt_wr;
    logic                  prio_ok;
    logic [2:0]            grp;
    logic [63:0]           bits_wide;
    logic [1:0]            status;
    logic                  resched;
    logic [5:0]            enc_top;
    logic                  enc_any;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept = req_valid && req_ready;
    assign complete = (state_reg == ST_UPDATE) && (!rsp_valid_reg || rsp_ready);
    assign addr = prio_reg[PRIO_W-1:0];
    assign grp = prio_reg[5:3];
    assign prio_ok = {1'b0, prio_reg} < 7'(PRIO_COUNT);
    assign cnt = valid_reg[addr] ? rd_data : '0;

    rbps_ram #(
        .WIDTH(CNT_W),
        .DEPTH(PRIO_COUNT)
    ) u_count_ram (
        .clk    (clk),
        .wr_en  (complete && cnt_wr),
        .wr_addr(addr),
        .wr_data(cnt_next),
        .rd_en  (accept),
        .rd_addr(req.priority_req[PRIO_W-1:0]),
        .rd_data(rd_data)
    );

    always_comb
    begin
        cnt_next = cnt;
        cnt_wr = 1'b0;
        status = STATUS_OK;
        resched = 1'b0;
        prio_bits_next = prio_bits_reg;
        group_bits_next = group_bits_reg;
        lock_next = lock_reg;
        bits_wide = '0;
        unique case (cmd_reg)
            CMD_READY:
            begin
                if (prio_ok)
                begin
                    if (cnt == CNT_MAX)
                    begin
                        status = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        cnt_next = cnt + 1'b1;
                        cnt_wr = 1'b1;
                    end
                    prio_bits_next[addr] = 1'b1;
                    group_bits_next[grp] = 1'b1;
                end
            end
            CMD_UNREADY:
            begin
                if (prio_ok)
                begin
                    if (cnt == '0)
                    begin
                        status = STATUS_EMPTY;
                    end
                    else
                    begin
                        cnt_next = cnt - 1'b1;
                        cnt_wr = 1'b1;
                        if (cnt == CNT_W'(1))
                        begin
                            prio_bits_next[addr] = 1'b0;
                            bits_wide = 64'(prio_bits_next);
                            if (bits_wide[{grp, 3'b000} +: 8] == 8'd0)
                            begin
                                group_bits_next[grp] = 1'b0;
                            end
                        end
                    end
                end
            end
            CMD_LOCK:
            begin
                if (lock_reg != LOCK_MAX)
                begin
                    lock_next = lock_reg + 1'b1;
                end
            end
            CMD_UNLOCK:
            begin
                if (lock_reg == '0)
                begin
                    status = STATUS_NOT_LOCKED;
                end
                else
                begin
                    lock_next = lock_reg - 1'b1;
                    resched = (lock_reg == LOCK_W'(1));
                end
            end
            default:
            begin
                status = STATUS_OK;
            end
        endcase
    end

    rbps_encode u_encode (
        .prio_bits   (prio_bits_next),
        .group_bits  (group_bits_next),
        .top_priority(enc_top),
        .any_ready   (enc_any)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (complete)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            prio_bits_reg <= '0;
            group_bits_reg <= '0;
            lock_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (complete)
            begin
                prio_bits_reg <= prio_bits_next;
                group_bits_reg <= group_bits_next;
                lock_reg <= lock_next;
                rsp_valid_reg <= 1'b1;
                if (cnt_wr)
                begin
                    valid_reg[addr] <= 1'b1;
                end
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.cmd;
            prio_reg <= req.priority_req;
        end
        if (complete)
        begin
            rsp_reg.top_priority <= enc_top;
            rsp_reg.any_ready <= enc_any;
            rsp_reg.sched_allowed <= (lock_next == '0);
            rsp_reg.reschedule <= resched;
            rsp_reg.status <= status;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule
